// ===== rtl/lre_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Laplacian regularizer entry generator.
package lre_pkg;

    localparam int MAX_STRIKE_DEF = 64;
    localparam int MAX_DIP_DEF    = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIKE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIP_COUNT    = 2'd1;

    localparam int DIV_NUM_W         = 60;
    localparam int DIV_DEN_W         = 32;
    localparam int DIV_QUOT_W        = 48;
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = DIV_NUM_W / DIV_BITS_PER_STEP;

    typedef struct packed {
        logic [5:0]  strike_index;
        logic [5:0]  dip_index;
        logic [15:0] patch_width;
        logic [15:0] patch_length;
    } patch_t;

    typedef struct packed {
        logic [13:0]        matrix_row;
        logic [12:0]        matrix_column;
        logic signed [47:0] entry_value;
        logic               last_entry;
    } entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] numer;
        logic [DIV_DEN_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_QUOT_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } lre_state_t;

endpackage

// ===== rtl/lre_divider.sv =====
`timescale 1ns / 1ps
// Rounding restoring divider, four quotient bits per cycle.
module lre_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  lre_pkg::div_req_t req,
    output lre_pkg::div_rsp_t rsp
);

    localparam int NUM_W = lre_pkg::DIV_NUM_W;
    localparam int DEN_W = lre_pkg::DIV_DEN_W;
    localparam int BITS  = lre_pkg::DIV_BITS_PER_STEP;
    localparam int STEPS = lre_pkg::DIV_STEPS;
    localparam int CNT_W = $clog2(STEPS);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quot;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        rem       = rem_reg;
        num       = num_reg;
        quot      = quot_reg;
        trial     = '0;
        if (req.start)
        begin
            // round to nearest: add half the divisor up front
            run_next  = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.denom;
            num_next  = req.numer + NUM_W'(req.denom >> 1);
            quot_next = '0;
        end
        else if (run_reg)
        begin
            for (int k = 0; k < BITS; k++)
            begin
                trial = {rem, num[NUM_W-1]};
                num   = num << 1;
                if (trial >= {1'b0, den_reg})
                begin
                    trial = trial - {1'b0, den_reg};
                    quot  = {quot[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    quot = {quot[NUM_W-2:0], 1'b0};
                end
                rem = trial[DEN_W-1:0];
            end
            rem_next  = rem;
            num_next  = num;
            quot_next = quot;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg[lre_pkg::DIV_QUOT_W-1:0];

endmodule

// ===== rtl/laplacian_regularizer_entries_core.sv =====
`timescale 1ns / 1ps
// Top level: sparse Laplacian regularizer entry generator with its sequencer.
//
// Usage:
//   patch channel (patch_valid / patch_stall / patch) takes one fault patch per
//   request, in row-major order. entry channel (entry_valid / entry_stall / entry)
//   returns 4 to 10 entries per in-grid patch; last_entry marks the final one.
//   cfg channel writes strike_count (index 0) and dip_count (index 1); cfg_ready
//   is always high. Write only while the block is idle.
// Timing:
//   After a patch is taken, the setup state forms the grid indices, then the
//   shared divider computes 1e6/w^2, 1e6/l^2 and 1e8/(w*l) in turn, each in
//   15 steps of four quotient bits. Entries are then registered one per cycle
//   while entry_stall is low. patch_stall is high after a patch is taken until
//   the last entry is loaded into the output register; for a patch outside the
//   grid it drops again after the setup state.
// Reset: counts return to 1, the penalty row offset clears, no entry is valid.
// A stall on the entry channel holds the output register and, in the emit state, the sequencer.
module laplacian_regularizer_entries_core #(
    parameter int MAX_STRIKE = lre_pkg::MAX_STRIKE_DEF,
    parameter int MAX_DIP    = lre_pkg::MAX_DIP_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              patch_valid,
    output logic                              patch_stall,
    input  lre_pkg::patch_t                   patch,
    output logic                              entry_valid,
    input  logic                              entry_stall,
    output lre_pkg::entry_t                   entry,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lre_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lre_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [15:0] ONE_KM_Q8 = 16'd256;
    localparam logic [lre_pkg::DIV_NUM_W-1:0] NUM_STENCIL =
        lre_pkg::DIV_NUM_W'(64'd1000000 << 32);
    localparam logic [lre_pkg::DIV_NUM_W-1:0] NUM_PENALTY =
        lre_pkg::DIV_NUM_W'(64'd100000000 << 32);

    localparam logic [1:0] PHASE_A = 2'd0;
    localparam logic [1:0] PHASE_B = 2'd1;
    localparam logic [1:0] PHASE_P = 2'd2;

    localparam int TAPS      = 5;
    localparam int SLOTS     = 12;
    localparam int SLOT_W    = 4;
    localparam int TAP_UP    = 0;
    localparam int TAP_BACK  = 1;
    localparam int TAP_DIAG  = 2;
    localparam int TAP_FWD   = 3;
    localparam int TAP_DOWN  = 4;
    localparam int SLOT_PEN0 = 2 * TAPS;
    localparam int SLOT_PEN1 = 2 * TAPS + 1;

    lre_pkg::lre_state_t state_reg, state_next;

    logic [6:0]         strike_count_reg, strike_count_next;
    logic [6:0]         dip_count_reg, dip_count_next;
    logic [13:0]        offset_reg, offset_next;
    logic [SLOTS-1:0]   mask_reg, mask_next;
    logic [1:0]         phase_reg, phase_next;
    logic               entry_valid_reg, entry_valid_next;

    logic [5:0]         i_reg, i_next;
    logic [5:0]         j_reg, j_next;
    logic [15:0]        w_reg, w_next;
    logic [15:0]        l_reg, l_next;
    logic [12:0]        patch_reg, patch_next;
    logic [13:0]        pen_row_reg, pen_row_next;
    logic [31:0]        prod_reg, prod_next;
    logic [47:0]        a_reg, a_next;
    logic [47:0]        b_reg, b_next;
    logic [47:0]        p_reg, p_next;
    lre_pkg::entry_t    entry_reg, entry_next;

    lre_pkg::div_req_t  div_req;
    lre_pkg::div_rsp_t  div_rsp;

    logic [6:0]         ns_eff, nd_eff;
    logic               in_grid, boundary;
    logic [12:0]        patch_calc;
    logic [13:0]        base_calc;
    logic [SLOTS-1:0]   mask_calc;
    logic [15:0]        mul_x, mul_y;
    logic [31:0]        mul_p;
    logic [SLOT_W-1:0]  slot;
    logic [SLOTS-1:0]   slot_bit, mask_rest;
    logic               slot_m, slot_pen;
    int                 slot_tap;
    logic [12:0]        nb_delta, nb_patch;
    logic [47:0]        ab_sum, diag_val, slot_val;
    logic [13:0]        slot_row;

    lre_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lre_pkg::ST_IDLE;
            strike_count_reg <= 7'd1;
            dip_count_reg    <= 7'd1;
            offset_reg       <= '0;
            mask_reg         <= '0;
            phase_reg        <= PHASE_A;
            entry_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            strike_count_reg <= strike_count_next;
            dip_count_reg    <= dip_count_next;
            offset_reg       <= offset_next;
            mask_reg         <= mask_next;
            phase_reg        <= phase_next;
            entry_valid_reg  <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        w_reg       <= w_next;
        l_reg       <= l_next;
        patch_reg   <= patch_next;
        pen_row_reg <= pen_row_next;
        prod_reg    <= prod_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        p_reg       <= p_next;
        entry_reg   <= entry_next;
    end

    // grid geometry
    assign ns_eff = (32'(strike_count_reg) > MAX_STRIKE) ? 7'(MAX_STRIKE) : strike_count_reg;
    assign nd_eff = (32'(dip_count_reg) > MAX_DIP) ? 7'(MAX_DIP) : dip_count_reg;
    assign in_grid  = ({1'b0, i_reg} < ns_eff) && ({1'b0, j_reg} < nd_eff);
    assign boundary = ({1'b0, j_reg} == nd_eff - 7'd1) || (i_reg == 6'd0)
                      || ({1'b0, i_reg} == ns_eff - 7'd1);
    assign patch_calc = 13'(j_reg) * 13'(ns_eff) + 13'(i_reg);
    assign base_calc  = 14'((14'(ns_eff) * 14'(nd_eff)) << 1);

    always_comb
    begin
        mask_calc                  = '0;
        mask_calc[TAP_UP]          = (j_reg != 6'd0);
        mask_calc[TAP_BACK]        = (i_reg != 6'd0);
        mask_calc[TAP_DIAG]        = 1'b1;
        mask_calc[TAP_FWD]         = ({1'b0, i_reg} + 7'd1 < ns_eff);
        mask_calc[TAP_DOWN]        = ({1'b0, j_reg} + 7'd1 < nd_eff);
        mask_calc[TAPS+TAP_UP]     = mask_calc[TAP_UP];
        mask_calc[TAPS+TAP_BACK]   = mask_calc[TAP_BACK];
        mask_calc[TAPS+TAP_DIAG]   = 1'b1;
        mask_calc[TAPS+TAP_FWD]    = mask_calc[TAP_FWD];
        mask_calc[TAPS+TAP_DOWN]   = mask_calc[TAP_DOWN];
        mask_calc[SLOT_PEN0]       = boundary;
        mask_calc[SLOT_PEN1]       = boundary;
    end

    // shared multiplier: w*w in setup, then l*l and w*l between divisions
    assign mul_x = (state_reg == lre_pkg::ST_WAIT && phase_reg == PHASE_A) ? l_reg : w_reg;
    assign mul_y = (state_reg == lre_pkg::ST_SETUP) ? w_reg : l_reg;
    assign mul_p = mul_x * mul_y;

    assign div_req.start = (state_reg == lre_pkg::ST_START);
    assign div_req.numer = (phase_reg == PHASE_P) ? NUM_PENALTY : NUM_STENCIL;
    assign div_req.denom = prod_reg;

    // next pending entry
    always_comb
    begin
        slot = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
                slot = SLOT_W'(k);
        end
    end

    assign slot_bit  = SLOTS'(1) << slot;
    assign mask_rest = mask_reg & ~slot_bit;
    assign ab_sum    = a_reg + b_reg;
    assign diag_val  = 48'd0 - (ab_sum << 1);

    always_comb
    begin
        slot_pen = (32'(slot) >= SLOT_PEN0);
        if (slot_pen)
        begin
            slot_m   = (32'(slot) == SLOT_PEN1);
            slot_tap = TAP_DIAG;
        end
        else if (32'(slot) >= TAPS)
        begin
            slot_m   = 1'b1;
            slot_tap = 32'(slot) - TAPS;
        end
        else
        begin
            slot_m   = 1'b0;
            slot_tap = 32'(slot);
        end
        case (slot_tap)
            TAP_UP:
            begin
                nb_delta = 13'd0 - 13'(ns_eff);
                slot_val = a_reg;
            end
            TAP_BACK:
            begin
                nb_delta = 13'h1FFF;
                slot_val = b_reg;
            end
            TAP_FWD:
            begin
                nb_delta = 13'd1;
                slot_val = b_reg;
            end
            TAP_DOWN:
            begin
                nb_delta = 13'(ns_eff);
                slot_val = a_reg;
            end
            default:
            begin
                nb_delta = 13'd0;
                slot_val = diag_val;
            end
        endcase
        if (slot_pen)
        begin
            slot_val = p_reg;
            slot_row = pen_row_reg + 14'(slot_m);
        end
        else
        begin
            slot_row = {patch_reg, slot_m};
        end
    end

    assign nb_patch = patch_reg + nb_delta;

    always_comb
    begin
        state_next        = state_reg;
        strike_count_next = strike_count_reg;
        dip_count_next    = dip_count_reg;
        offset_next       = offset_reg;
        mask_next         = mask_reg;
        phase_next        = phase_reg;
        entry_valid_next  = entry_valid_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        w_next            = w_reg;
        l_next            = l_reg;
        patch_next        = patch_reg;
        pen_row_next      = pen_row_reg;
        prod_next         = prod_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        p_next            = p_reg;
        entry_next        = entry_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                lre_pkg::CFG_STRIKE_COUNT: strike_count_next = cfg_data;
                lre_pkg::CFG_DIP_COUNT:    dip_count_next    = cfg_data;
                default:                   ;
            endcase
        end

        if (entry_valid_reg && !entry_stall)
            entry_valid_next = 1'b0;

        case (state_reg)
            lre_pkg::ST_IDLE:
            begin
                if (patch_valid)
                begin
                    i_next = patch.strike_index;
                    j_next = patch.dip_index;
                    w_next = (patch.patch_width < ONE_KM_Q8) ? ONE_KM_Q8 : patch.patch_width;
                    l_next = (patch.patch_length < ONE_KM_Q8) ? ONE_KM_Q8 : patch.patch_length;
                    if (patch.strike_index == 6'd0 && patch.dip_index == 6'd0)
                        offset_next = '0;
                    state_next = lre_pkg::ST_SETUP;
                end
            end
            lre_pkg::ST_SETUP:
            begin
                if (!in_grid)
                begin
                    state_next = lre_pkg::ST_IDLE;
                end
                else
                begin
                    patch_next   = patch_calc;
                    mask_next    = mask_calc;
                    pen_row_next = base_calc + offset_reg;
                    if (boundary)
                        offset_next = offset_reg + 14'd2;
                    prod_next  = mul_p;
                    phase_next = PHASE_A;
                    state_next = lre_pkg::ST_START;
                end
            end
            lre_pkg::ST_START:
            begin
                state_next = lre_pkg::ST_WAIT;
            end
            lre_pkg::ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (phase_reg)
                        PHASE_A:
                        begin
                            a_next     = div_rsp.quotient;
                            prod_next  = mul_p;
                            phase_next = PHASE_B;
                            state_next = lre_pkg::ST_START;
                        end
                        PHASE_B:
                        begin
                            b_next     = div_rsp.quotient;
                            prod_next  = mul_p;
                            phase_next = PHASE_P;
                            state_next = lre_pkg::ST_START;
                        end
                        default:
                        begin
                            p_next     = div_rsp.quotient;
                            state_next = lre_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            lre_pkg::ST_EMIT:
            begin
                if (!entry_valid_reg || !entry_stall)
                begin
                    entry_next.matrix_row    = slot_row;
                    entry_next.matrix_column = {nb_patch[11:0], slot_m};
                    entry_next.entry_value   = $signed(slot_val);
                    entry_next.last_entry    = (mask_rest == '0);
                    entry_valid_next         = 1'b1;
                    mask_next                = mask_rest;
                    if (mask_rest == '0)
                        state_next = lre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lre_pkg::ST_IDLE;
            end
        endcase
    end

    assign patch_stall = (state_reg != lre_pkg::ST_IDLE);
    assign entry_valid = entry_valid_reg;
    assign entry       = entry_reg;
    assign cfg_ready   = 1'b1;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == lre_pkg::ST_WAIT)
        else $error("divider result outside wait state");

    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lre_pkg::ST_EMIT |-> mask_reg != '0)
        else $error("emit state with no pending entry");

    a_not_last_keeps_emit: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid_reg && !entry_reg.last_entry |-> state_reg == lre_pkg::ST_EMIT)
        else $error("patch ended without last entry");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streamed Laplacian regularizer entry generator.
module testbench;

    localparam logic [lre_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [lre_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  SETTLE_CYCLES  = 100;
    localparam int  RANDOM_ITEMS   = 135;
    localparam longint unsigned STENCIL_SCALE = 64'd1000000 << 32;
    localparam longint unsigned PENALTY_SCALE = 64'd100000000 << 32;

    class entry_scoreboard;
        lre_pkg::entry_t expected_q[$];
        logic [6:0]      strike_count;
        logic [6:0]      dip_count;
        logic [15:0]     penalty_offset;
        int              mismatches;

        function new();
            strike_count   = 7'd1;
            dip_count      = 7'd1;
            penalty_offset = '0;
            mismatches     = 0;
        endfunction

        function void write_register(logic [lre_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [lre_pkg::CFG_DATA_W-1:0] data);
            if (idx == lre_pkg::CFG_STRIKE_COUNT)
                strike_count = data;
            else if (idx == lre_pkg::CFG_DIP_COUNT)
                dip_count = data;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_entry(longint unsigned row, longint unsigned col,
                                longint unsigned val);
            lre_pkg::entry_t e;
            e.matrix_row    = row[13:0];
            e.matrix_column = col[12:0];
            e.entry_value   = val[47:0];
            e.last_entry    = 1'b0;
            expected_q.push_back(e);
        endfunction

        // Expected stencil and penalty entries for one accepted patch.
        function void note_patch(lre_pkg::patch_t p);
            longint unsigned i, j, w, l, ns, nd, idx, a, b, diag, pen, base, m;
            lre_pkg::entry_t tail;
            i  = p.strike_index;
            j  = p.dip_index;
            w  = p.patch_width;
            l  = p.patch_length;
            ns = (strike_count > lre_pkg::MAX_STRIKE_DEF) ? lre_pkg::MAX_STRIKE_DEF
                                                          : strike_count;
            nd = (dip_count > lre_pkg::MAX_DIP_DEF) ? lre_pkg::MAX_DIP_DEF : dip_count;
            if (w < 256)
                w = 256;
            if (l < 256)
                l = 256;
            if (i == 0 && j == 0)
                penalty_offset = '0;
            if (i >= ns || j >= nd)
                return;
            idx  = j * ns + i;
            a    = (STENCIL_SCALE + (w * w) / 2) / (w * w);
            b    = (STENCIL_SCALE + (l * l) / 2) / (l * l);
            pen  = (PENALTY_SCALE + (w * l) / 2) / (w * l);
            diag = 64'd0 - 64'd2 * (a + b);
            for (m = 0; m < 2; m++)
            begin
                if (j > 0)
                    add_entry(2 * idx + m, 2 * (idx - ns) + m, a);
                if (i > 0)
                    add_entry(2 * idx + m, 2 * (idx - 1) + m, b);
                add_entry(2 * idx + m, 2 * idx + m, diag);
                if (i + 1 < ns)
                    add_entry(2 * idx + m, 2 * (idx + 1) + m, b);
                if (j + 1 < nd)
                    add_entry(2 * idx + m, 2 * (idx + ns) + m, a);
            end
            if (j == nd - 1 || i == 0 || i == ns - 1)
            begin
                base = 2 * ns * nd;
                for (m = 0; m < 2; m++)
                begin
                    add_entry(base + penalty_offset, 2 * idx + m, pen);
                    penalty_offset = penalty_offset + 16'd1;
                end
            end
            tail = expected_q.pop_back();
            tail.last_entry = 1'b1;
            expected_q.push_back(tail);
        endfunction

        function void check_entry(lre_pkg::entry_t got);
            lre_pkg::entry_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected entry: row %0d col %0d value %0d last %0b",
                             got.matrix_row, got.matrix_column, got.entry_value,
                             got.last_entry);
                return;
            end
            want = expected_q.pop_front();
            if (got.matrix_row !== want.matrix_row ||
                got.matrix_column !== want.matrix_column ||
                got.entry_value !== want.entry_value ||
                got.last_entry !== want.last_entry)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"entry mismatch: expected row %0d col %0d value %0d last %0b,",
                              " got row %0d col %0d value %0d last %0b"},
                             want.matrix_row, want.matrix_column, want.entry_value,
                             want.last_entry, got.matrix_row, got.matrix_column,
                             got.entry_value, got.last_entry);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            patch_valid;
    logic                            patch_stall;
    lre_pkg::patch_t                 patch;
    logic                            entry_valid;
    logic                            entry_stall;
    lre_pkg::entry_t                 entry;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lre_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lre_pkg::CFG_DATA_W-1:0]  cfg_data;

    entry_scoreboard sb;
    int burst_left;
    int idle_cycles;
    int stall_pct;
    int stall_window;
    int stall_hold;

    laplacian_regularizer_entries_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .patch_valid (patch_valid),
        .patch_stall (patch_stall),
        .patch       (patch),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry       (entry),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int rand_size();
        case ($urandom_range(7))
            0: return $urandom_range(255);
            1: return 65535;
            2: return 256;
            3: return $urandom_range(256, 2048);
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic idle(input int cycles);
        patch_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic push_patch(input int i, input int j, input int w, input int l);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0)
                idle(gap);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        patch_valid        <= 1'b1;
        patch.strike_index <= i[5:0];
        patch.dip_index    <= j[5:0];
        patch.patch_width  <= w[15:0];
        patch.patch_length <= l[15:0];
        @(posedge clk);
        while (patch_stall)
            @(posedge clk);
        sb.note_patch(patch);
    endtask

    task automatic wait_results();
        patch_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [lre_pkg::CFG_INDEX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[lre_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, data[lre_pkg::CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Block must be quiet before its counts change.
    task automatic set_grid(input int strike, input int dip);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(lre_pkg::CFG_STRIKE_COUNT, strike);
        write_reg(lre_pkg::CFG_DIP_COUNT, dip);
    endtask

    // Receiver stall pattern: windows of varying density plus rare long holds.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (entry_valid && !entry_stall)
                sb.check_entry(entry);
            if (stall_hold > 0)
            begin
                entry_stall <= 1'b1;
                stall_hold--;
            end
            else
            begin
                if (stall_window == 0)
                begin
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        2: stall_pct = 40;
                        default: stall_pct = 75;
                    endcase
                    stall_window = $urandom_range(100, 400);
                end
                else
                    stall_window--;
                if ($urandom_range(999) == 0)
                    stall_hold = $urandom_range(10, 40);
                entry_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((patch_valid && !patch_stall) || (entry_valid && !entry_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        int random_sent;
        int phase_len;
        int ns;
        int nd;
        int si;
        int di;
        int k;
        int s;
        int d;

        clk          = 1'b0;
        rst_n        = 1'b0;
        patch_valid  = 1'b0;
        patch        = '0;
        entry_stall  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sb           = new();
        burst_left   = 0;
        idle_cycles  = 0;
        stall_pct    = 0;
        stall_window = 0;
        stall_hold   = 0;
        random_sent  = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid is 1x1: clamping and out-of-grid patches.
        push_patch(0, 0, 0, 0);
        push_patch(0, 0, 255, 65535);
        push_patch(1, 0, 300, 300);
        push_patch(63, 63, 65535, 0);

        // Full 4x3 sweep, then out-of-order patches.
        set_grid(4, 3);
        for (k = 0; k < 12; k++)
            push_patch(k % 4, k / 4, (k == 5) ? 65535 : rand_size(),
                       (k == 6) ? 256 : rand_size());
        push_patch(2, 2, rand_size(), rand_size());
        push_patch(1, 0, rand_size(), rand_size());

        // Counts above the maximum saturate.
        set_grid(127, 127);
        push_patch(0, 0, 65535, 65535);
        push_patch(63, 0, 256, 256);
        push_patch(5, 7, rand_size(), rand_size());
        push_patch(63, 63, rand_size(), rand_size());
        push_patch(0, 63, rand_size(), rand_size());

        // Zero count leaves the grid empty; spare indexes change nothing.
        set_grid(0, 5);
        write_reg(CFG_SPARE_A, 127);
        write_reg(CFG_SPARE_B, 3);
        push_patch(0, 0, rand_size(), rand_size());
        push_patch(3, 2, rand_size(), rand_size());

        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0: begin s = 1; d = 1; end
                1: begin s = 64; d = 64; end
                2: begin s = $urandom_range(65, 127); d = $urandom_range(1, 4); end
                3: begin s = $urandom_range(0, 3); d = 0; end
                4: begin s = 1; d = $urandom_range(1, 64); end
                5: begin s = $urandom_range(1, 64); d = 1; end
                default: begin s = $urandom_range(1, 6); d = $urandom_range(1, 6); end
            endcase
            set_grid(s, d);
            ns = (s > lre_pkg::MAX_STRIKE_DEF) ? lre_pkg::MAX_STRIKE_DEF : s;
            nd = (d > lre_pkg::MAX_DIP_DEF) ? lre_pkg::MAX_DIP_DEF : d;
            phase_len = $urandom_range(8, 24);
            si = 0;
            di = 0;
            for (k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++)
            begin
                if (ns == 0 || nd == 0 || $urandom_range(4) == 0)
                begin
                    if ($urandom_range(1) == 0)
                        push_patch($urandom_range(63), $urandom_range(63),
                                   rand_size(), rand_size());
                    else
                        push_patch($urandom_range(ns), $urandom_range(nd),
                                   rand_size(), rand_size());
                end
                else
                begin
                    // Row-major sweep, with an occasional skipped patch.
                    if ($urandom_range(9) == 0)
                        si++;
                    if (si >= ns)
                    begin
                        si = 0;
                        di++;
                    end
                    if (di >= nd)
                        di = 0;
                    push_patch(si, di, rand_size(), rand_size());
                    si++;
                    if (si >= ns)
                    begin
                        si = 0;
                        di++;
                    end
                    if (di >= nd)
                        di = 0;
                end
                random_sent++;
                if ($urandom_range(30) == 0)
                    wait_results();
            end
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lre_pkg.sv
rtl/lre_divider.sv
rtl/laplacian_regularizer_entries_core.sv
tb/testbench.sv
